[hdl/npps_pkg.sv]
// Shared types, constants and register indexes for the nearest projected point search.
package npps_pkg;

  localparam int unsigned DefMaxPoints = 1048576;

  // Configuration register indexes.
  localparam logic [2:0] RegFocalX  = 3'd0;
  localparam logic [2:0] RegFocalY  = 3'd1;
  localparam logic [2:0] RegCenterX = 3'd2;
  localparam logic [2:0] RegCenterY = 3'd3;
  localparam logic [2:0] RegShiftX  = 3'd4;
  localparam logic [2:0] RegShiftY  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DIST,
    ST_SQR,
    ST_CMP,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word
    logic mul;       // form numerators
    logic div_start; // start both dividers
    logic diff;      // form pixel differences
    logic sqr;       // square the differences
    logic cmp;       // compare and update best
    logic clear;     // clear the search
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic div_done;
    logic is_last;
    logic counting;  // point count below the limit
  } stat_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

[hdl/npps_divider.sv]
// Radix-2 restoring divider for unsigned 64-bit magnitudes, one bit per cycle.
module npps_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);

  logic [63:0] quot;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  count;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] rem_shift;

  // Shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem[31:0], quot[63]};
    trial = rem_shift - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial;
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quot <= {quot[62:0], 1'b0};
      end
    end
  end

  assign quotient = quot;

endmodule

[hdl/npps_datapath.sv]
// Datapath: configuration registers, projection, distance and best-point tracking.
module npps_datapath #(
  parameter int unsigned MAX_POINTS = npps_pkg::DefMaxPoints
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                cmd,
  input  logic signed [31:0]  target_u,
  input  logic signed [31:0]  target_v,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  input  logic                last,
  input  npps_pkg::cmd_t      ctl,
  output npps_pkg::stat_t     sts,
  output logic                valid_res,
  output logic signed [31:0]  near_x,
  output logic signed [31:0]  near_y,
  output logic signed [31:0]  near_z,
  output logic [19:0]         near_index
);

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  logic [31:0] focal_x, focal_y;
  logic signed [31:0] center_x, center_y, shift_x, shift_y;
  logic signed [31:0] goal_u, goal_v;
  logic signed [31:0] in_x, in_y, in_z;
  logic in_last;
  logic signed [63:0] num_x, num_y;
  logic [63:0] best_distance;
  logic signed [31:0] best_x, best_y, best_z;
  logic [CntW-1:0] best_position, points_seen;
  logic [63:0] quo_x, quo_y;
  logic done_x, done_y, dvx_done, dvy_done;
  logic signed [33:0] diff_u, diff_v;
  logic [31:0] mag_u, mag_v;
  logic [63:0] sq_u, sq_v;
  logic [63:0] distance;
  logic [64:0] sum;
  logic [31:0] zmag;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= '0; focal_y <= '0; center_x <= '0;
      center_y <= '0; shift_x <= '0; shift_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        npps_pkg::RegFocalX:  focal_x <= cfg_data;
        npps_pkg::RegFocalY:  focal_y <= cfg_data;
        npps_pkg::RegCenterX: center_x <= cfg_data;
        npps_pkg::RegCenterY: center_y <= cfg_data;
        npps_pkg::RegShiftX:  shift_x <= cfg_data;
        npps_pkg::RegShiftY:  shift_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_last <= last;
      in_x <= coord_x; in_y <= coord_y; in_z <= coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_u <= '0; goal_v <= '0;
    end else if (ctl.load && !cmd) begin
      goal_u <= target_u; goal_v <= target_v;
    end
  end

  // Numerators: signed product plus shift in Q32.32, saturated.
  function automatic logic signed [63:0] numer(input logic [31:0] f,
                                               input logic signed [31:0] c,
                                               input logic signed [31:0] s);
    logic signed [65:0] p;
    logic signed [65:0] n;
    p = $signed({34'd0, f}) * 66'(c);
    n = p + (66'(s) <<< 16);
    if (n > 66'sh0_7FFF_FFFF_FFFF_FFFF) numer = 64'h7FFF_FFFF_FFFF_FFFF;
    else if (n < -66'sh0_8000_0000_0000_0000) numer = 64'h8000_0000_0000_0000;
    else numer = n[63:0];
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      num_x <= numer(focal_x, in_x, shift_x);
      num_y <= numer(focal_y, in_y, shift_y);
    end
  end

  assign zmag = 32'(npps_pkg::mag64(64'(in_z)));

  npps_divider u_div_x (
    .clk(clk), .rst(rst), .start(ctl.div_start),
    .dividend(npps_pkg::mag64(num_x)), .divisor(zmag),
    .quotient(quo_x), .done(done_x)
  );

  npps_divider u_div_y (
    .clk(clk), .rst(rst), .start(ctl.div_start),
    .dividend(npps_pkg::mag64(num_y)), .divisor(zmag),
    .quotient(quo_y), .done(done_y)
  );

  // Both dividers run in lockstep; hold their done flags until the next divider start.
  always_ff @(posedge clk) begin
    if (rst || ctl.div_start) begin
      dvx_done <= 1'b0; dvy_done <= 1'b0;
    end else begin
      if (done_x) dvx_done <= 1'b1;
      if (done_y) dvy_done <= 1'b1;
    end
  end

  // Clamp, sign, add center, saturate and subtract goal.
  function automatic logic signed [33:0] pix_diff(input logic [63:0] qm_in,
                                                  input logic neg,
                                                  input logic signed [31:0] ctr,
                                                  input logic signed [31:0] g);
    logic [34:0] qm;
    logic signed [36:0] q;
    logic signed [36:0] u;
    logic signed [31:0] us;
    qm = (qm_in > 64'h4_0000_0000) ? 35'h4_0000_0000 : qm_in[34:0];
    q = neg ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
    u = q + 37'(ctr);
    if (u > 37'sh0_7FFF_FFFF) us = 32'h7FFF_FFFF;
    else if (u < -37'sh0_8000_0000) us = 32'h8000_0000;
    else us = u[31:0];
    pix_diff = 34'(us) - 34'(g);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.diff) begin
      diff_u <= pix_diff(quo_x, num_x[63] ^ in_z[31], center_x, goal_u);
      diff_v <= pix_diff(quo_y, num_y[63] ^ in_z[31], center_y, goal_v);
    end
  end

  // Exact squares; the difference magnitudes fit in 32 bits.
  assign mag_u = 32'(npps_pkg::mag64(64'(diff_u)));
  assign mag_v = 32'(npps_pkg::mag64(64'(diff_v)));

  always_ff @(posedge clk) begin
    if (ctl.sqr) begin
      sq_u <= {32'd0, mag_u} * {32'd0, mag_u};
      sq_v <= {32'd0, mag_v} * {32'd0, mag_v};
    end
  end

  assign sum = {1'b0, sq_u} + {1'b0, sq_v};
  assign distance = (in_z == 32'sd0 || sum[64]) ? '1 : sum[63:0];

  // Best-point tracking and point count.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best_distance <= '1;
      best_x <= '0; best_y <= '0; best_z <= '0;
      best_position <= '0;
      points_seen <= '0;
    end else if (ctl.cmp) begin
      if (points_seen == '0 || distance < best_distance) begin
        best_distance <= distance;
        best_x <= in_x; best_y <= in_y; best_z <= in_z;
        best_position <= points_seen;
      end
      points_seen <= points_seen + 1'b1;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (ctl.load && !cmd) begin
      valid_res <= 1'b0;
      near_x <= '0; near_y <= '0; near_z <= '0; near_index <= '0;
    end else if (ctl.clear) begin
      valid_res <= (points_seen != '0);
      near_x <= best_x; near_y <= best_y; near_z <= best_z;
      near_index <= 20'(best_position);
    end
  end

  always_comb begin
    sts.div_done = dvx_done && dvy_done;
    sts.is_last = in_last;
    sts.counting = (points_seen < CntW'(MAX_POINTS));
  end

endmodule

[hdl/npps_control.sv]
// Controller state machine sequencing one word at a time through the datapath.
module npps_control (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            cmd,
  input  logic            last,
  input  npps_pkg::stat_t sts,
  output npps_pkg::cmd_t  ctl
);

  npps_pkg::state_t state, state_next;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npps_pkg::ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    out_full_next = out_full && out_stall;
    in_stall = 1'b1;
    case (state)
      npps_pkg::ST_IDLE: begin
        // A new word needs the result register free if it may emit.
        in_stall = out_full;
        if (in_valid && !in_stall) begin
          ctl.load = 1'b1;
          if (!cmd) begin
            ctl.clear = 1'b1;
            if (last) out_full_next = 1'b1;
          end else begin
            state_next = npps_pkg::ST_MUL;
          end
        end
      end
      npps_pkg::ST_MUL: begin
        if (sts.counting) begin
          ctl.mul = 1'b1;
          state_next = npps_pkg::ST_DIV;
        end else begin
          state_next = npps_pkg::ST_OUT;
        end
      end
      npps_pkg::ST_DIV: begin
        ctl.div_start = 1'b1;
        state_next = npps_pkg::ST_DIST;
      end
      npps_pkg::ST_DIST: begin
        if (sts.div_done) begin
          ctl.diff = 1'b1;
          state_next = npps_pkg::ST_SQR;
        end
      end
      npps_pkg::ST_SQR: begin
        ctl.sqr = 1'b1;
        state_next = npps_pkg::ST_CMP;
      end
      npps_pkg::ST_CMP: begin
        ctl.cmp = 1'b1;
        state_next = npps_pkg::ST_OUT;
      end
      npps_pkg::ST_OUT: begin
        if (sts.is_last) begin
          ctl.clear = 1'b1;
          out_full_next = 1'b1;
        end
        state_next = npps_pkg::ST_IDLE;
      end
      default: state_next = npps_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_full;

  // The result register is never overwritten while a word waits in it.
  assert property (@(posedge clk) disable iff (rst)
    out_full && out_stall |=> out_full)
    else $error("pending result word lost");
  assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> state == npps_pkg::ST_IDLE && !out_full)
    else $error("word loaded while busy or output full");
  assert property (@(posedge clk) disable iff (rst)
    ctl.clear && state == npps_pkg::ST_OUT |-> !out_full)
    else $error("result emitted over a pending word");

endmodule

[hdl/nearest_projected_point_search_core.sv]
// Top level of the nearest projected point search core.
// Usage: write focal_x, focal_y, center_x, center_y, shift_x, shift_y
// through cfg_we/cfg_index/cfg_data while idle. Then send a query word
// (cmd = 0) with target_u/target_v, followed by point words (cmd = 1),
// the final one marked with last. Each point is projected with a
// pinhole model and the nearest to the target is kept; the first one
// wins ties. On the last point one result word appears on the output
// channel with the kept point and its index; a query word with last set
// gives a result word with valid_res = 0.
// Flow: a point word passes through capture, multiply, divider start, the
// two bit-serial dividers that run side by side, registering of their done
// flags, pixel difference, square, compare and emit; the one-bit-per-cycle
// dividers set the pace. A point past the count limit goes from multiply
// straight to emit, and a query word is finished at capture.
// Words are handled one at a time.
// Reset clears configuration, goal and search; no result is pending.
// While the receiver stalls with a result word pending, the result word
// holds and a new input word is not taken.
module nearest_projected_point_search_core #(
  parameter int unsigned MAX_POINTS = npps_pkg::DefMaxPoints
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] target_u,
  input  logic signed [31:0] target_v,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               valid_res,
  output logic signed [31:0] near_x,
  output logic signed [31:0] near_y,
  output logic signed [31:0] near_z,
  output logic [19:0]        near_index
);

  npps_pkg::cmd_t  ctl;
  npps_pkg::stat_t sts;

  npps_control u_control (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .last(last),
    .sts(sts), .ctl(ctl)
  );

  npps_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .target_u(target_u),
    .target_v(target_v), .coord_x(coord_x), .coord_y(coord_y),
    .coord_z(coord_z), .last(last), .ctl(ctl), .sts(sts),
    .valid_res(valid_res), .near_x(near_x), .near_y(near_y),
    .near_z(near_z), .near_index(near_index)
  );

endmodule

[tb/sv/nearest_projected_point_search_core_tb.sv]
// Self-checking testbench for the nearest projected point search core.
`timescale 1ns / 100ps

module nearest_projected_point_search_core_tb;

  // Packed input word as queued for the driver.
  typedef struct packed {
    logic        cmd;
    logic [31:0] tu;
    logic [31:0] tv;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic        last;
  } word_t;

  // One expected result word.
  typedef struct packed {
    logic        vres;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [19:0] idx;
  } nearest_t;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic cmd, last;
  logic signed [31:0] target_u, target_v, coord_x, coord_y, coord_z;
  logic valid_res;
  logic signed [31:0] near_x, near_y, near_z;
  logic [19:0] near_index;

  nearest_projected_point_search_core DUT (.*);

  // Predictor state.
  logic [31:0] p_focal_x, p_focal_y, p_center_x, p_center_y, p_shift_x, p_shift_y;
  logic [31:0] goal_u, goal_v;
  logic [63:0] best_dist;
  logic [31:0] best_x, best_y, best_z;
  logic [19:0] best_pos;
  logic [20:0] seen;

  word_t pending_words[$];
  nearest_t nearest_queue[$];
  int errors = 0;
  int in_gap = 0, out_gap = 0, hold_cycles = 0;
  bit calm = 0;
  bit hold_req = 0, hold_done = 0;
  logic hold = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Generous time limit.
  initial begin
    #(64'd12 * 64'd3_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("Mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void queue_word(input word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic void expect_nearest(input nearest_t r);
    nearest_queue.insert(nearest_queue.size(), r);
  endfunction

  function automatic logic [63:0] magn(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Pinhole projection of one coordinate into a saturated Q16.16 pixel.
  function automatic logic signed [63:0] project_pixel(input logic signed [31:0] c,
      input logic [31:0] focal, input logic signed [31:0] shift,
      input logic signed [31:0] center, input logic signed [31:0] z);
    logic [63:0] pm, qm;
    logic signed [63:0] p, s, q, u;
    logic signed [64:0] n;
    logic signed [63:0] ns;
    pm = {32'd0, focal} * magn(64'(c));
    p = c[31] ? -$signed(pm) : $signed(pm);
    s = 64'(shift) <<< 16;
    n = 65'(p) + 65'(s);
    if (n > 65'sh0_7FFF_FFFF_FFFF_FFFF) ns = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (n < -65'sh0_8000_0000_0000_0000) ns = 64'sh8000_0000_0000_0000;
    else ns = n[63:0];
    qm = magn(ns) / magn(64'(z));
    if (qm > (64'd1 << 34)) qm = 64'd1 << 34;
    q = (ns[63] != z[31]) ? -$signed(qm) : $signed(qm);
    u = q + 64'(center);
    if (u > 64'sd2147483647) u = 64'sd2147483647;
    if (u < -64'sd2147483648) u = -64'sd2147483648;
    return u;
  endfunction

  function automatic void clear_search();
    best_dist = '1; best_x = 0; best_y = 0; best_z = 0; best_pos = 0; seen = 0;
  endfunction

  // Advance the predictor by one accepted word.
  function automatic void predict_nearest(input word_t w);
    logic [63:0] du, dv, d;
    logic signed [63:0] u, v;
    logic [64:0] sum;
    if (!w.cmd) begin
      goal_u = w.tu; goal_v = w.tv;
      clear_search();
      if (w.last) expect_nearest('0);
      return;
    end
    if (seen < 21'(npps_pkg::DefMaxPoints)) begin
      if (w.cz == 0) d = '1;
      else begin
        u = project_pixel(w.cx, p_focal_x, p_shift_x, p_center_x, w.cz);
        v = project_pixel(w.cy, p_focal_y, p_shift_y, p_center_y, w.cz);
        du = magn(u - 64'($signed(goal_u))); du = du * du;
        dv = magn(v - 64'($signed(goal_v))); dv = dv * dv;
        sum = 65'(du) + 65'(dv);
        d = sum[64] ? '1 : sum[63:0];
      end
      if (seen == 0 || d < best_dist) begin
        best_dist = d; best_x = w.cx; best_y = w.cy; best_z = w.cz; best_pos = seen[19:0];
      end
      seen++;
    end
    if (w.last) begin
      expect_nearest({seen != 0, best_x, best_y, best_z, best_pos});
      clear_search();
    end
  endfunction

  // Driver: offers queued words with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_nearest({cmd, target_u, target_v, coord_x, coord_y, coord_z, last});
        void'(pending_words.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (pending_words.size() > 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 6);
          in_valid <= 0;
        end else begin
          in_valid <= 1;
          {cmd, target_u, target_v, coord_x, coord_y, coord_z, last} <= pending_words[0];
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Long receiver hold-off, counted once on request.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      if (hold_cycles == 800) begin
        hold <= 0;
        hold_done <= 1;
      end else begin
        hold <= 1;
        hold_cycles <= hold_cycles + 1;
      end
    end
  end

  // Monitor: checks each result word and applies receiver stalls.
  always @(posedge clk) begin
    nearest_t e;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (nearest_queue.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          e = nearest_queue.pop_front();
          if (valid_res !== e.vres) report("valid_res", valid_res, e.vres);
          if (near_x !== e.x) report("near_x", near_x, e.x);
          if (near_y !== e.y) report("near_y", near_y, e.y);
          if (near_z !== e.z) report("near_z", near_z, e.z);
          if (near_index !== e.idx) report("near_index", near_index, e.idx);
        end
      end
      if (hold) begin
        out_stall <= 1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 6);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 0;
      3: return $urandom();
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic word_t query_word(input logic [31:0] u, input logic [31:0] v,
                                       input logic lst);
    return {1'b0, u, v, $urandom(), $urandom(), $urandom(), lst};
  endfunction

  function automatic word_t point_word(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z, input logic lst);
    return {1'b1, $urandom(), $urandom(), x, y, z, lst};
  endfunction

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || nearest_queue.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      npps_pkg::RegFocalX: p_focal_x = val;
      npps_pkg::RegFocalY: p_focal_y = val;
      npps_pkg::RegCenterX: p_center_x = val;
      npps_pkg::RegCenterY: p_center_y = val;
      npps_pkg::RegShiftX: p_shift_x = val;
      npps_pkg::RegShiftY: p_shift_y = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_config();
    write_reg(npps_pkg::RegFocalX,
              $urandom_range(0, 3) == 0 ? rand_val() : $urandom_range(1, 1000 << 16));
    write_reg(npps_pkg::RegFocalY,
              $urandom_range(0, 3) == 0 ? rand_val() : $urandom_range(1, 1000 << 16));
    write_reg(npps_pkg::RegCenterX, rand_val());
    write_reg(npps_pkg::RegCenterY, rand_val());
    write_reg(npps_pkg::RegShiftX, rand_val());
    write_reg(npps_pkg::RegShiftY, rand_val());
  endtask

  // Stimulus sequence.
  initial begin
    int n;
    int next_cfg;
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; out_stall = 0;
    {cmd, target_u, target_v, coord_x, coord_y, coord_z, last} = '0;
    p_focal_x = 0; p_focal_y = 0; p_center_x = 0; p_center_y = 0;
    p_shift_x = 0; p_shift_y = 0; goal_u = 0; goal_v = 0;
    clear_search();
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed: a point before any query, with the reset configuration.
    queue_word(point_word(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b1));
    wait_idle();
    write_reg(npps_pkg::RegFocalX, 32'h01F4_0000);
    write_reg(npps_pkg::RegFocalY, 32'hFFFF_FFFF);
    write_reg(npps_pkg::RegCenterX, 32'h0140_0000);
    write_reg(npps_pkg::RegCenterY, 32'h8000_0000);
    write_reg(npps_pkg::RegShiftX, 32'h7FFF_FFFF);
    write_reg(npps_pkg::RegShiftY, 32'h0);
    // Empty cloud, query without last, zero depth first, ties, negative depth.
    queue_word(query_word(32'h0140_0000, 32'h00F0_0000, 1'b1));
    queue_word(query_word(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    queue_word(point_word(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0));
    queue_word(point_word(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0));
    queue_word(point_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 1'b0));
    queue_word(point_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 1'b0));
    queue_word(point_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0));
    queue_word(point_word(32'h0, 32'h0, 32'h8000_0000, 1'b0));
    queue_word(point_word(32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 1'b1));
    queue_word(query_word(32'h0, 32'h0, 1'b0));
    queue_word(point_word(32'h0, 32'h0, 32'h0, 1'b1));
    wait_idle();

    // Random phases: mostly well-formed clouds under changing settings.
    n = 0;
    next_cfg = 0;
    while (n < 1350) begin
      if (n >= next_cfg) begin
        wait_idle();
        random_config();
        next_cfg += 200;
      end
      // Long receiver hold-off while the sender keeps offering words.
      if (n >= 600) hold_req = 1;
      if (n > 1150) calm = 1;
      if ($urandom_range(0, 9) != 0)
        queue_word(query_word(rand_val(), rand_val(), $urandom_range(0, 9) == 0));
      repeat ($urandom_range(1, 6)) begin
        queue_word(point_word(rand_val(), rand_val(),
          $urandom_range(0, 9) == 0 ? 32'h0 : rand_val(), $urandom_range(0, 7) == 0));
        n++;
      end
      queue_word(point_word(rand_val(), rand_val(), rand_val(), 1'b1));
      n += 2;
      while (pending_words.size() > 20) @(posedge clk);
    end

    // Final drain and verdict.
    wait_idle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
hdl/npps_pkg.sv
hdl/npps_divider.sv
hdl/npps_datapath.sv
hdl/npps_control.sv
hdl/nearest_projected_point_search_core.sv
tb/sv/nearest_projected_point_search_core_tb.sv
